### design/taw_pkg.sv
// Shared types, constants and codes for the tar archive header walker.
`default_nettype none
package taw_pkg;

    localparam int BLOCK_BYTES      = 512;
    localparam int SIZE_DIGITS      = 11;
    localparam int SIZE_OFFSET      = 124;
    localparam int POS_BITS         = 9;
    localparam int SIZE_BITS        = 33;
    localparam int LEFT_BITS        = 24;
    localparam int BLK_BITS         = 32;
    localparam int INDEX_BITS_DEF   = 32;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_DATA   = 2'd1,
        MODE_ENDED  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] archive_byte;
        logic       restart;
    } t_in_word;

    typedef struct packed {
        logic                 kind;
        logic [BLK_BITS-1:0]  header_block;
        logic [SIZE_BITS-1:0] entry_size;
        logic                 bad_digit;
    } t_out_word;

endpackage
`default_nettype wire

### design/tar_archive_header_walker.sv
// Top level of the tar archive header walker.
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one archive byte per
//   word, with restart set on the first byte of each new archive.
//   Output channel (o_out_valid / i_out_ready / o_out_word) gives one word per
//   entry header (after its last byte) and one at the end-of-archive block.
//   A result is registered when the byte that causes it is accepted.
//   Throughput: one byte per cycle while o_in_ready is high, set by the
//   single register stage of the scanner state.
//   A result register plus one skid entry sit behind the scanner; o_in_ready
//   drops only while both hold results, so the skid entry absorbs one result
//   during a receiver stall, and a stall that outlasts it holds the input.
//   After the end-of-archive word, bytes are consumed and dropped until a byte
//   with restart set.
//   Reset (synchronous, active low) clears the scanner to header mode at block
//   zero and empties the output register and skid entry.
`default_nettype none
module tar_archive_header_walker #(
    parameter int INDEX_BITS = taw_pkg::INDEX_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  taw_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output taw_pkg::t_out_word  o_out_word
);

    logic               w_accept;
    logic               w_res_valid;
    taw_pkg::t_out_word w_res_word;

    assign w_accept = i_in_valid && o_in_ready;

    taw_scan #(
        .INDEX_BITS(INDEX_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_word      (i_in_word),
        .o_res_valid (w_res_valid),
        .o_res_word  (w_res_word)
    );

    taw_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_word  (w_res_word),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.kind == taw_pkg::KIND_END) |->
        (o_out_word.entry_size == '0 && !o_out_word.bad_digit))
        else $error("end word carries size or bad digit");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("output not empty after reset");

    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_accept)
        else $error("result produced without an accepted byte");

endmodule
`default_nettype wire

### design/taw_scan.sv
// Header scanner: block position, size digits and data block skipping.
`default_nettype none
module taw_scan #(
    parameter int INDEX_BITS = taw_pkg::INDEX_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  taw_pkg::t_in_word   i_word,
    output logic                o_res_valid,
    output taw_pkg::t_out_word  o_res_word
);

    localparam int PB = taw_pkg::POS_BITS;
    localparam int SB = taw_pkg::SIZE_BITS;
    localparam int LB = taw_pkg::LEFT_BITS;
    localparam int BB = taw_pkg::BLK_BITS;

    taw_pkg::t_mode       r_mode, n_mode, c_mode;
    logic [PB-1:0]        r_pos, n_pos, c_pos;
    logic [INDEX_BITS-1:0] r_cnt, n_cnt, c_cnt;
    logic [BB-1:0]        r_hs, n_hs;
    logic [SB-1:0]        r_acc, n_acc;
    logic [LB-1:0]        r_left, n_left, c_left;
    logic                 r_err, n_err;
    logic [BB-1:0]        w_cnt32;
    logic                 w_last;
    logic [2:0]           w_digit;
    logic [LB:0]          w_blocks;
    logic [LB:0]          w_blocks_m1;

    generate
        if (INDEX_BITS > BB) begin : g_sat
            assign w_cnt32 = (|c_cnt[INDEX_BITS-1:BB]) ? {BB{1'b1}} : c_cnt[BB-1:0];
        end else if (INDEX_BITS == BB) begin : g_eq
            assign w_cnt32 = c_cnt;
        end else begin : g_ext
            assign w_cnt32 = {{(BB-INDEX_BITS){1'b0}}, c_cnt};
        end
    endgenerate

    always_comb begin
        c_mode = i_word.restart ? taw_pkg::MODE_HEADER : r_mode;
        c_pos  = i_word.restart ? '0 : r_pos;
        c_cnt  = i_word.restart ? '0 : r_cnt;
        c_left = i_word.restart ? '0 : r_left;

        n_mode = r_mode;
        n_pos  = r_pos;
        n_cnt  = r_cnt;
        n_hs   = r_hs;
        n_acc  = r_acc;
        n_left = r_left;
        n_err  = r_err;

        w_last      = (c_pos == PB'(taw_pkg::BLOCK_BYTES - 1));
        w_digit     = 3'd0;
        w_blocks    = '0;
        w_blocks_m1 = '0;
        o_res_valid = 1'b0;
        o_res_word  = '0;

        if (i_accept && c_mode != taw_pkg::MODE_ENDED) begin
            n_mode = c_mode;
            n_pos  = c_pos;
            n_cnt  = c_cnt;
            n_left = c_left;
            if (c_mode == taw_pkg::MODE_HEADER && c_pos == '0 &&
                i_word.archive_byte == 8'd0) begin
                o_res_valid             = 1'b1;
                o_res_word.kind         = taw_pkg::KIND_END;
                o_res_word.header_block = w_cnt32;
                n_mode                  = taw_pkg::MODE_ENDED;
            end else begin
                case (c_mode)
                    taw_pkg::MODE_HEADER: begin
                        if (c_pos == '0) begin
                            n_hs  = w_cnt32;
                            n_acc = '0;
                            n_err = 1'b0;
                        end
                        if (c_pos >= PB'(taw_pkg::SIZE_OFFSET) &&
                            c_pos <  PB'(taw_pkg::SIZE_OFFSET + taw_pkg::SIZE_DIGITS)) begin
                            if (i_word.archive_byte inside
                                {[taw_pkg::CHAR_ZERO:taw_pkg::CHAR_SEVEN]}) begin
                                w_digit = i_word.archive_byte[2:0];
                            end else begin
                                n_err = 1'b1;
                            end
                            n_acc = {n_acc[SB-4:0], w_digit};
                        end
                        if (w_last) begin
                            o_res_valid             = 1'b1;
                            o_res_word.kind         = taw_pkg::KIND_ENTRY;
                            o_res_word.header_block = r_hs;
                            o_res_word.entry_size   = r_acc;
                            o_res_word.bad_digit    = r_err;
                            w_blocks    = (LB+1)'(r_acc[SB-1:PB]) +
                                          (LB+1)'(|r_acc[PB-1:0]);
                            w_blocks_m1 = w_blocks - (LB+1)'(1);
                            if (r_acc != '0) begin
                                n_mode = taw_pkg::MODE_DATA;
                                n_left = w_blocks_m1[LB-1:0];
                            end
                        end
                    end
                    taw_pkg::MODE_DATA: begin
                        if (w_last) begin
                            if (c_left == '0) begin
                                n_mode = taw_pkg::MODE_HEADER;
                            end else begin
                                n_left = c_left - LB'(1);
                            end
                        end
                    end
                    default: begin
                        n_mode = c_mode;
                    end
                endcase
                if (w_last) begin
                    n_pos = '0;
                    if (!(&c_cnt)) begin
                        n_cnt = c_cnt + INDEX_BITS'(1);
                    end
                end else begin
                    n_pos = c_pos + PB'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= taw_pkg::MODE_HEADER;
            r_pos  <= '0;
            r_cnt  <= '0;
            r_hs   <= '0;
            r_acc  <= '0;
            r_left <= '0;
            r_err  <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_cnt  <= n_cnt;
            r_hs   <= n_hs;
            r_acc  <= n_acc;
            r_left <= n_left;
            r_err  <= n_err;
        end
    end

endmodule
`default_nettype wire

### design/taw_out_buf.sv
// Result register with one skid entry behind it.
`default_nettype none
module taw_out_buf (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  taw_pkg::t_out_word  i_word,
    output logic                o_room,
    output logic                o_valid,
    input  wire                 i_ready,
    output taw_pkg::t_out_word  o_word
);

    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    taw_pkg::t_out_word r_out, n_out;
    taw_pkg::t_out_word r_skid, n_skid;
    logic               w_take;

    always_comb begin
        w_take       = r_out_valid && i_ready;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = i_push;
                n_skid       = i_word;
            end else begin
                n_out_valid = i_push;
                n_out       = i_word;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = i_word;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_room  = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule
`default_nettype wire

### dv/tar_archive_header_walker_tb.sv
// Testbench for the tar archive header walker: streams archives, predicts entry and end words.
module tar_archive_header_walker_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import taw_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int FULL_DATA    = -1;
    localparam int STOP_WORDS   = 75;
    localparam int STOP_BYTES   = 150_000;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } t_fill;

    typedef struct packed {
        logic                     restart;
        logic [7:0]               first;
        logic [8*SIZE_DIGITS-1:0] digits;
        t_fill                    fill;
        int                       data_len;
        logic                     typed;
        t_out_word                want;
    } t_block_row;

    localparam t_out_word NO_WORD = '0;

    localparam t_block_row DIRECTED [13] = '{
        '{1'b1, 8'h00, "00000000000", FILL_RANDOM, 20, 1'b1,
          '{KIND_END, 32'd0, 33'd0, 1'b0}},
        '{1'b1, "a", "00000000000", FILL_RANDOM, 0, 1'b1,
          '{KIND_ENTRY, 32'd0, 33'd0, 1'b0}},
        '{1'b0, 8'hFF, "00000001000", FILL_ONES, FULL_DATA, 1'b1,
          '{KIND_ENTRY, 32'd1, 33'd512, 1'b0}},
        '{1'b0, 8'h01, "00000001001", FILL_ZEROS, FULL_DATA, 1'b1,
          '{KIND_ENTRY, 32'd3, 33'd513, 1'b0}},
        '{1'b0, "c", "00000000001", FILL_RANDOM, FULL_DATA, 1'b1,
          '{KIND_ENTRY, 32'd6, 33'd1, 1'b0}},
        '{1'b0, "d", "0000000x010", FILL_RANDOM, FULL_DATA, 1'b1,
          '{KIND_ENTRY, 32'd8, 33'd8, 1'b1}},
        '{1'b0, "e", "77777777777", FILL_ONES, 700, 1'b1,
          '{KIND_ENTRY, 32'd10, 33'h1_FFFF_FFFF, 1'b0}},
        '{1'b1, "f", {"/89:", 8'h00, 8'hFF, " 0012"}, FILL_RANDOM, FULL_DATA, 1'b0,
          NO_WORD},
        '{1'b0, "g", "10000000000", FILL_RANDOM, 300, 1'b0, NO_WORD},
        '{1'b1, 8'hFF, "00000000777", FILL_ZEROS, FULL_DATA, 1'b0, NO_WORD},
        '{1'b0, 8'h00, "00000000000", FILL_RANDOM, 30, 1'b0, NO_WORD},
        '{1'b1, 8'h80, "00000002000", FILL_RANDOM, FULL_DATA, 1'b1,
          '{KIND_ENTRY, 32'd0, 33'd1024, 1'b0}},
        '{1'b0, 8'h00, "00000000000", FILL_RANDOM, 5, 1'b1,
          '{KIND_END, 32'd3, 33'd0, 1'b0}}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    int        src_idle_pct  = 32;
    int        sink_idle_pct = 50;
    int        fail_count    = 0;
    int        cycle_count   = 0;
    int        results_made  = 0;
    int        bytes_sent    = 0;
    t_out_word pending_words [$];
    t_out_word head_word;

    logic [POS_BITS-1:0]  sc_pos;
    t_mode                sc_mode;
    logic [BLK_BITS-1:0]  sc_block;
    logic [BLK_BITS-1:0]  sc_hdr;
    logic [SIZE_BITS-1:0] sc_size;
    logic [LEFT_BITS-1:0] sc_left;
    logic                 sc_bad;

    tar_archive_header_walker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic void clear_scan();
        sc_pos   = '0;
        sc_mode  = MODE_HEADER;
        sc_block = '0;
        sc_hdr   = '0;
        sc_size  = '0;
        sc_left  = '0;
        sc_bad   = 1'b0;
    endfunction

    function automatic logic [33:0] blocks_needed();
        return ({1'b0, sc_size} + BLOCK_BYTES - 1) / BLOCK_BYTES;
    endfunction

    function automatic logic [8*SIZE_DIGITS-1:0] octal_digits(input logic [SIZE_BITS-1:0] size);
        logic [8*SIZE_DIGITS-1:0] d;
        for (int k = 0; k < SIZE_DIGITS; k++) begin
            d[8*k +: 8] = CHAR_ZERO + size[3*k +: 3];
        end
        return d;
    endfunction

    function automatic logic scan_byte(input t_in_word w, output t_out_word r);
        logic        last;
        logic [33:0] blocks;
        scan_byte = 1'b0;
        r = '0;
        if (w.restart) begin
            clear_scan();
        end
        if (sc_mode == MODE_ENDED) begin
            return 1'b0;
        end
        last = (sc_pos == BLOCK_BYTES - 1);
        if (sc_mode == MODE_HEADER) begin
            if (sc_pos == 0) begin
                if (w.archive_byte == 8'h00) begin
                    r.kind         = KIND_END;
                    r.header_block = sc_block;
                    sc_mode        = MODE_ENDED;
                    results_made++;
                    return 1'b1;
                end
                sc_hdr  = sc_block;
                sc_size = '0;
                sc_bad  = 1'b0;
            end
            if (sc_pos >= SIZE_OFFSET && sc_pos < SIZE_OFFSET + SIZE_DIGITS) begin
                if (w.archive_byte >= CHAR_ZERO && w.archive_byte <= CHAR_SEVEN) begin
                    sc_size = (sc_size << 3) + SIZE_BITS'(w.archive_byte - CHAR_ZERO);
                end else begin
                    sc_size = sc_size << 3;
                    sc_bad  = 1'b1;
                end
            end
            if (last) begin
                r.kind         = KIND_ENTRY;
                r.header_block = sc_hdr;
                r.entry_size   = sc_size;
                r.bad_digit    = sc_bad;
                scan_byte      = 1'b1;
                results_made++;
                blocks = blocks_needed();
                if (blocks != 0) begin
                    sc_mode = MODE_DATA;
                    sc_left = LEFT_BITS'(blocks - 1);
                end
            end
        end else if (last) begin
            if (sc_left == 0) begin
                sc_mode = MODE_HEADER;
            end else begin
                sc_left--;
            end
        end
        if (last) begin
            sc_pos = '0;
            if (sc_block != '1) begin
                sc_block++;
            end
        end else begin
            sc_pos++;
        end
    endfunction

    task automatic send_word(input t_in_word w, input logic typed, input t_out_word want);
        t_out_word got;
        if (scan_byte(w, got)) begin
            pending_words.insert(pending_words.size(), typed ? want : got);
        end
        bytes_sent++;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_header(input logic restart, input logic [7:0] first,
                               input logic [8*SIZE_DIGITS-1:0] digits, input t_fill fill,
                               input int len, input logic typed, input t_out_word want);
        t_in_word w;
        for (int p = 0; p < len; p++) begin
            w.restart = (p == 0) ? restart : 1'b0;
            if (p == 0) begin
                w.archive_byte = first;
            end else if (p >= SIZE_OFFSET && p < SIZE_OFFSET + SIZE_DIGITS) begin
                w.archive_byte = digits[8*(SIZE_OFFSET + SIZE_DIGITS - 1 - p) +: 8];
            end else begin
                case (fill)
                    FILL_ONES:  w.archive_byte = 8'hFF;
                    FILL_ZEROS: w.archive_byte = 8'h00;
                    default:    w.archive_byte = 8'($urandom_range(0, 255));
                endcase
            end
            send_word(w, typed, want);
        end
    endtask

    task automatic send_data(input int count);
        t_in_word w;
        for (int k = 0; k < count; k++) begin
            w.restart      = 1'b0;
            w.archive_byte = 8'($urandom_range(0, 255));
            send_word(w, 1'b0, NO_WORD);
        end
    endtask

    task automatic send_archive();
        int                       entries;
        int                       pick;
        int                       cut;
        int                       slot;
        logic [SIZE_BITS-1:0]     size;
        logic [8*SIZE_DIGITS-1:0] digits;
        logic [33:0]              blocks;
        entries = $urandom_range(1, 5);
        for (int e = 0; e < entries; e++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                size = '0;
            end else if (pick < 75) begin
                size = SIZE_BITS'($urandom_range(1, 4096));
            end else begin
                size = {1'($urandom_range(0, 1)), $urandom()};
                size = size >> $urandom_range(0, 32);
            end
            digits = octal_digits(size);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                slot = $urandom_range(0, SIZE_DIGITS - 1);
                digits[8*slot +: 8] = 8'($urandom_range(0, 255));
            end else if (pick < 14) begin
                for (int k = 0; k < SIZE_DIGITS; k++) begin
                    digits[8*k +: 8] = 8'($urandom_range(0, 255));
                end
            end
            cut = ($urandom_range(0, 99) < 3) ? $urandom_range(1, BLOCK_BYTES - 1) : BLOCK_BYTES;
            send_header(e == 0, 8'($urandom_range(1, 255)), digits, FILL_RANDOM, cut,
                        1'b0, NO_WORD);
            if (cut < BLOCK_BYTES) begin
                return;
            end
            blocks = blocks_needed();
            // abandon huge entries; the next archive restarts mid-data
            if (blocks > 8) begin
                send_data($urandom_range(0, 1200));
                return;
            end
            if ($urandom_range(0, 99) < 4) begin
                send_data($urandom_range(0, int'(blocks) * BLOCK_BYTES));
                return;
            end
            send_data(int'(blocks) * BLOCK_BYTES);
        end
        if ($urandom_range(0, 99) < 85) begin
            send_header(1'b0, 8'h00, digits, FILL_RANDOM, 1, 1'b0, NO_WORD);
            send_data($urandom_range(0, 40));
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && out_ready) begin
            if (pending_words.size() == 0) begin
                $error("result word with nothing expected: %h", out_word);
                fail_count++;
            end else begin
                head_word = pending_words.pop_front();
                check_field("kind", head_word.kind, out_word.kind);
                check_field("header_block", head_word.header_block, out_word.header_block);
                check_field("entry_size", head_word.entry_size, out_word.entry_size);
                check_field("bad_digit", head_word.bad_digit, out_word.bad_digit);
            end
        end
        out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_block_row row;
        clear_scan();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        foreach (DIRECTED[i]) begin
            row = DIRECTED[i];
            send_header(row.restart, row.first, row.digits, row.fill,
                        (row.first == 8'h00) ? 1 : BLOCK_BYTES, row.typed, row.want);
            if (row.data_len == FULL_DATA) begin
                send_data(int'(blocks_needed()) * BLOCK_BYTES);
            end else begin
                send_data(row.data_len);
            end
        end
        while (results_made < STOP_WORDS && bytes_sent < STOP_BYTES) begin
            if (results_made < 30) begin
                src_idle_pct  = 32;
                sink_idle_pct = 50;
            end else if (results_made < 55) begin
                src_idle_pct  = 50;
                sink_idle_pct = 32;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            send_archive();
        end
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
design/taw_pkg.sv
design/taw_scan.sv
design/taw_out_buf.sv
design/tar_archive_header_walker.sv
dv/tar_archive_header_walker_tb.sv
